/* rtl/wlm_pkg.sv */
package wlm_pkg;

    localparam int MaxPattern = 16;
    localparam int PatBytes   = 16;
    localparam int UsedBytes  = (MaxPattern < PatBytes) ? MaxPattern : PatBytes;
    localparam int RowW       = UsedBytes + 1;
    localparam int LenW       = 5;
    localparam int CfgW       = 64;
    localparam int QDepth     = 2;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    localparam logic [7:0] ChAny  = 8'h3F;
    localparam logic [7:0] ChStar = 8'h2A;
    localparam logic [7:0] ChLowA = 8'h61;
    localparam logic [7:0] ChLowZ = 8'h7A;
    localparam logic [7:0] CaseOff = 8'h20;

    typedef enum logic [1:0] {
        RegPatternLow    = 2'd0,
        RegPatternHigh   = 2'd1,
        RegPatternLength = 2'd2,
        RegIgnoreCase    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [UsedBytes-1:0] in_use;
        logic [UsedBytes-1:0] star;
        logic [RowW-1:0]      row_zero;
        logic [LenW-1:0]      used_len;
    } pat_info_t;

    typedef struct packed {
        logic [UsedBytes-1:0] hit;
        logic                 last;
    } entry_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && c >= ChLowA && c <= ChLowZ)
        begin
            r = c - CaseOff;
        end
        return r;
    endfunction

endpackage

/* rtl/wildcard_line_matcher.sv */
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] char_in, tlast line_end
// m_axis    out        tdata[0] line_matches, tdata[7:1] zero
// cfg       in         cfg_index 0..3 selects register, cfg_data 64 bits
//
// One character per cycle while the queue has room; the row update is
// a prefix-OR chain over the 16 pattern positions in the back stage.
// A two-entry queue sits between classification and the row update.
// One result per line, registered as the line end leaves the queue
// and held in an output register until transferred; a line end waits in the
// queue while that register is occupied, and the input stalls once it is full.
// Reset clears the pattern registers, queue and line state.
module wildcard_line_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] line_matches, [7:1] zero
);
    import wlm_pkg::*;

    entry_t    f_entry;
    entry_t    q_entry;
    pat_info_t info;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    logic      push;
    logic      match_bit;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    wlm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .char_in   (s_tdata),
        .line_end  (s_tlast),
        .entry     (f_entry),
        .info      (info)
    );

    wlm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (f_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_entry),
        .not_empty (q_valid)
    );

    wlm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .info        (info),
        .entry       (q_entry),
        .entry_valid (q_valid),
        .entry_pop   (q_pop),
        .out_valid   (m_tvalid),
        .out_match   (match_bit),
        .out_ready   (m_tready)
    );

    assign m_tdata = {7'd0, match_bit};

endmodule

/* rtl/wlm_front.sv */
module wlm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [7:0]           char_in,
    input  logic                 line_end,
    output wlm_pkg::entry_t      entry,
    output wlm_pkg::pat_info_t   info
);
    import wlm_pkg::*;

    logic [63:0]     pat_low_reg;
    logic [63:0]     pat_high_reg;
    logic [LenW-1:0] pat_len_reg;
    logic            ign_case_reg;
    logic [127:0]    pat_all;
    logic [7:0]      ch_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            ign_case_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                RegPatternLow:    pat_low_reg  <= cfg_data;
                RegPatternHigh:   pat_high_reg <= cfg_data;
                RegPatternLength: pat_len_reg  <= cfg_data[LenW-1:0];
                RegIgnoreCase:    ign_case_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign pat_all = {pat_high_reg, pat_low_reg};

    always_comb
    begin
        info.used_len = (pat_len_reg > LenW'(UsedBytes)) ? LenW'(UsedBytes) : pat_len_reg;
        info.row_zero = '0;
        info.row_zero[0] = 1'b1;
        for (int k = 0; k < UsedBytes; k++)
        begin
            info.in_use[k] = (LenW'(k) < info.used_len);
            info.star[k]   = (pat_all[8*k +: 8] == ChStar);
        end
        for (int k = 0; k < UsedBytes; k++)
        begin
            info.row_zero[k+1] = info.row_zero[k] & info.star[k] & info.in_use[k];
        end
    end

    // classify the incoming byte against every pattern position
    assign ch_f = fold_char(char_in, ign_case_reg);

    always_comb
    begin
        entry.last = line_end;
        for (int k = 0; k < UsedBytes; k++)
        begin
            entry.hit[k] = info.in_use[k] &&
                ((pat_all[8*k +: 8] == ChAny) ||
                 (fold_char(pat_all[8*k +: 8], ign_case_reg) == ch_f));
        end
    end

endmodule

/* rtl/wlm_queue.sv */
module wlm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wlm_pkg::entry_t  push_data,
    output logic             full,
    input  logic             pop,
    output wlm_pkg::entry_t  pop_data,
    output logic             not_empty
);
    import wlm_pkg::*;

    entry_t            mem_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg;
    logic [QPtrW-1:0]  rd_ptr_reg;
    logic [QCntW-1:0]  count_reg;
    logic [QCntW-1:0]  count_next;

    assign full      = (count_reg == QCntW'(QDepth));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* rtl/wlm_back.sv */
module wlm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wlm_pkg::pat_info_t  info,
    input  wlm_pkg::entry_t     entry,
    input  logic                entry_valid,
    output logic                entry_pop,
    output logic                out_valid,
    output logic                out_match,
    input  logic                out_ready
);
    import wlm_pkg::*;

    logic [RowW-1:0] row_reg;
    logic [RowW-1:0] row_next;
    logic [1:0]      seen_reg;
    logic [1:0]      seen_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_match_reg;
    logic [RowW-1:0] prev;
    logic [RowW-1:0] cur;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign entry_pop = entry_valid && (!entry.last || slot_free);
    assign prev      = (seen_reg == 2'd0) ? info.row_zero : row_reg;

    // advance the row; star positions carry a prefix OR
    always_comb
    begin
        cur = '0;
        for (int j = 1; j < RowW; j++)
        begin
            if (!info.in_use[j-1])
            begin
                cur[j] = 1'b0;
            end
            else if (info.star[j-1])
            begin
                cur[j] = prev[j] | cur[j-1];
            end
            else
            begin
                cur[j] = entry.hit[j-1] & prev[j-1];
            end
        end
    end

    always_comb
    begin
        row_next       = row_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (entry_pop)
        begin
            if (entry.last)
            begin
                row_next       = info.row_zero;
                seen_next      = 2'd0;
                out_valid_next = 1'b1;
            end
            else
            begin
                row_next  = cur;
                seen_next = (seen_reg == 2'd2) ? 2'd2 : seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= RowW'(1);
            seen_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_pop && entry.last)
        begin
            out_match_reg <= (seen_reg != 2'd0) && cur[info.used_len];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_match = out_match_reg;

endmodule
